FILE: rtl/i2p_pkg.sv
// Shared constants, character codes and helpers for the infix-to-postfix converter.
`default_nettype none

package i2p_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // precedence, with '(' and anything else at the bottom (0)
    typedef logic [1:0] rank_t;

    function automatic rank_t op_rank(input logic [7:0] ch);
        rank_t r;
        r = 2'd0;
        if (ch == CH_CARET) begin
            r = 2'd3;
        end else if (ch == CH_STAR || ch == CH_SLASH) begin
            r = 2'd2;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            r = 2'd1;
        end
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    endfunction

    function automatic logic is_op(input logic [7:0] ch);
        return op_rank(ch) != 2'd0;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/infix_to_postfix_converter.sv
// Infix-to-postfix converter top level: sequencer, stack control and output register.
// Usage:
//   Input words arrive on the s_ stream: s_tdata carries the infix character,
//   s_tuser says whether the word is a character (0) or an end of expression (1).
//   Result words leave on the m_ stream: m_tdata is the postfix character,
//   m_tuser[0] marks a real character, m_tuser[1] reports the sticky overflow
//   flag, m_tlast closes the run on the bare end marker.
// Timing:
//   One word is worked on at a time. Acceptance also starts the read of the
//   stack top; evaluation then takes one stack pop per step and ends with a
//   closing action. A letter, '(' or ignored character needs no pop; an
//   operator pops while the top ranks as high; ')' pops down to its '('; an end word pops every stack entry.
//   The pace is set by the single registered read port of the stack memory:
//   each pop waits for the next top to come out of the memory.
// Reset:
//   aresetn (synchronous, active low) empties the stack, clears the overflow
//   flag and empties the output register. Stack contents are not cleared.
// Stalls:
//   A result waits in the output register; the next word is still accepted
//   while it waits. Evaluation only holds when a further result must be sent
//   and the output register is still full.
`default_nettype none

module infix_to_postfix_converter (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tuser,   // [0] req_type
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] char_out
    output logic      [1:0] m_tuser,   // [0] char_valid, [1] overflow_seen
    output logic            m_tlast    // run_last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    localparam int CNT_W = i2p_pkg::CNT_W;
    localparam int PTR_W = i2p_pkg::PTR_W;

    logic             state_reg, state_next;
    logic             req_reg;
    logic [7:0]       ch_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;

    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_cv_reg;
    logic             m_ovf_reg;
    logic             m_last_reg;

    // stack memory port
    logic             mem_we, mem_re;
    logic [PTR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]       top;

    // evaluation decisions
    logic             want_emit, do_pop, do_push, fin, go;
    logic [7:0]       emit_ch;
    logic             emit_cv, emit_last;
    logic             has_top, out_free, accept;
    i2p_pkg::rank_t   p_rank, t_rank;
    logic             op_pops, rp_pops;
    logic [CNT_W-1:0] cnt_m1, cnt_m2;

    i2p_stack_mem u_stack (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (ch_reg),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (top)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign has_top  = (cnt_reg != '0);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);

    assign p_rank  = i2p_pkg::op_rank(ch_reg);
    assign t_rank  = i2p_pkg::op_rank(top);
    // pop while top ranks equal or higher; '^' stops on an equal rank
    assign op_pops = has_top && (p_rank <= t_rank)
                     && !((p_rank == t_rank) && (ch_reg == i2p_pkg::CH_CARET));
    assign rp_pops = has_top && (top != i2p_pkg::CH_LPAREN);

    // what the current stack top asks for, ignoring the output stall
    always_comb begin
        want_emit = 1'b0;
        emit_ch   = 8'h00;
        emit_cv   = 1'b1;
        emit_last = 1'b0;
        do_pop    = 1'b0;
        do_push   = 1'b0;
        fin       = 1'b1;
        if (req_reg == i2p_pkg::REQ_END) begin
            want_emit = 1'b1;
            if (has_top) begin
                emit_ch = top;
                do_pop  = 1'b1;
                fin     = 1'b0;
            end else begin
                emit_cv   = 1'b0;
                emit_last = 1'b1;
            end
        end else if (i2p_pkg::is_letter(ch_reg)) begin
            want_emit = 1'b1;
            emit_ch   = ch_reg;
        end else if (ch_reg == i2p_pkg::CH_LPAREN) begin
            do_push = 1'b1;
        end else if (ch_reg == i2p_pkg::CH_RPAREN) begin
            if (rp_pops) begin
                want_emit = 1'b1;
                emit_ch   = top;
                do_pop    = 1'b1;
                fin       = 1'b0;
            end else begin
                // drop the matching '(' if there is one
                do_pop = has_top;
            end
        end else if (i2p_pkg::is_op(ch_reg)) begin
            if (op_pops) begin
                want_emit = 1'b1;
                emit_ch   = top;
                do_pop    = 1'b1;
                fin       = 1'b0;
            end else begin
                do_push = 1'b1;
            end
        end
    end

    assign go = (state_reg == ST_EVAL) && (!want_emit || out_free);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = cnt_reg[PTR_W-1:0];
        mem_raddr  = cnt_m1[PTR_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mem_re     = has_top;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (go) begin
                    if (do_pop) begin
                        cnt_next = cnt_m1;
                        // fetch the next top only if evaluation goes on
                        mem_re    = !fin && (cnt_reg > CNT_W'(1));
                        mem_raddr = cnt_m2[PTR_W-1:0];
                    end
                    if (do_push) begin
                        if (cnt_reg == CNT_W'(i2p_pkg::STACK_DEPTH)) begin
                            ovf_next = 1'b1;
                        end else begin
                            mem_we   = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    if (emit_last) begin
                        ovf_next = 1'b0;
                    end
                    if (fin) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_tuser;
            ch_reg  <= s_tdata;
        end
    end

    // output register: loads a result, frees on the downstream handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (go && want_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && want_emit) begin
            m_data_reg <= emit_ch;
            m_cv_reg   <= emit_cv;
            m_last_reg <= emit_last;
            m_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_ovf_reg, m_cv_reg};
    assign m_tlast  = m_last_reg;

    // stack count stays within the storage
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(i2p_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    // the memory is never written and read in the same cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("stack read and write clash");

    // sending the end marker leaves an empty stack and a clear flag
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && want_emit && emit_last) |=> (cnt_reg == '0) && !ovf_reg)
        else $error("flush did not clear stack state");

    // the end marker carries no character
    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (!m_cv_reg && (m_data_reg == 8'h00)))
        else $error("end marker carries a character");

endmodule

`default_nettype wire

FILE: rtl/i2p_stack_mem.sv
// Operator stack storage: one write port, one read port with registered data.
`default_nettype none

module i2p_stack_mem (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [i2p_pkg::PTR_W-1:0] wr_addr,
    input  wire logic [7:0]               wr_data,
    input  wire logic                     rd_en,
    input  wire logic [i2p_pkg::PTR_W-1:0] rd_addr,
    output logic      [7:0]               rd_data
);

    logic [7:0] mem [i2p_pkg::STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // data holds until the next read, so a stalled pop keeps its top
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
